[hw/rtl/thfd_pkg.sv]
// Package for the temperature and humidity frame decoder.
// Holds the decoded-frame type shared by the front end, the queue and the back end.
// No dependencies.
`default_nettype none

package thfd_pkg;

	localparam int unsigned RAW_W = 16;
	localparam int unsigned TEMP_W = 15;
	localparam int unsigned HUMID_W = 14;

	typedef struct packed {
		logic [RAW_W-1:0] temp_raw;
		logic [RAW_W-1:0] humid_raw;
		logic             crc_ok;
	} frame_t;

endpackage

`default_nettype wire

[hw/rtl/thfd_front.sv]
// Front end of the frame decoder: accepts received bytes, tracks frame position and checks CRCs.
// Pushes one decoded frame per sixth byte into the queue. Depends on thfd_pkg.
`default_nettype none

module thfd_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire logic           in_stall,
	input  wire logic [7:0]     rx_byte,
	input  wire logic           frame_first,
	output logic                push_valid,
	output thfd_pkg::frame_t    push_frame
);
	import thfd_pkg::*;

	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;

	localparam logic [2:0] POS_TEMP_HI  = 3'd0;
	localparam logic [2:0] POS_TEMP_LO  = 3'd1;
	localparam logic [2:0] POS_TEMP_CRC = 3'd2;
	localparam logic [2:0] POS_HUM_HI   = 3'd3;
	localparam logic [2:0] POS_HUM_LO   = 3'd4;
	localparam logic [2:0] POS_HUM_CRC  = 3'd5;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

	logic [2:0] pos_q;
	logic [7:0] crc_q;
	logic [7:0] temp_hi_q;
	logic [7:0] temp_lo_q;
	logic [7:0] humid_hi_q;
	logic [7:0] humid_lo_q;
	logic       temp_ok_q;

	logic       accept;
	logic [2:0] pos_eff;

	assign accept  = in_valid && !in_stall;
	assign pos_eff = frame_first ? POS_TEMP_HI : pos_q;

	assign push_valid           = accept && (pos_eff == POS_HUM_CRC);
	assign push_frame.temp_raw  = {temp_hi_q, temp_lo_q};
	assign push_frame.humid_raw = {humid_hi_q, humid_lo_q};
	assign push_frame.crc_ok    = temp_ok_q && (rx_byte == crc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= POS_TEMP_HI;
			crc_q      <= CRC_INIT;
			temp_hi_q  <= '0;
			temp_lo_q  <= '0;
			humid_hi_q <= '0;
			humid_lo_q <= '0;
			temp_ok_q  <= 1'b0;
		end else if (accept) begin
			pos_q <= (pos_eff == POS_HUM_CRC) ? POS_TEMP_HI : pos_eff + 3'd1;
			unique case (pos_eff)
				POS_TEMP_HI: begin
					temp_hi_q <= rx_byte;
					crc_q     <= crc8_byte(CRC_INIT, rx_byte);
				end
				POS_TEMP_LO: begin
					temp_lo_q <= rx_byte;
					crc_q     <= crc8_byte(crc_q, rx_byte);
				end
				POS_TEMP_CRC: begin
					temp_ok_q <= (rx_byte == crc_q);
					crc_q     <= CRC_INIT;
				end
				POS_HUM_HI: begin
					humid_hi_q <= rx_byte;
					crc_q      <= crc8_byte(CRC_INIT, rx_byte);
				end
				POS_HUM_LO: begin
					humid_lo_q <= rx_byte;
					crc_q      <= crc8_byte(crc_q, rx_byte);
				end
				POS_HUM_CRC: begin
					crc_q <= CRC_INIT;
				end
				default: begin
					crc_q <= CRC_INIT;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[hw/rtl/thfd_queue.sv]
// Small FIFO of decoded frames between the front end and the back end.
// Depends on thfd_pkg.
`default_nettype none

module thfd_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	input  wire thfd_pkg::frame_t push_frame,
	output logic                  full,
	output logic                  pop_valid,
	input  wire logic             pop_stall,
	output thfd_pkg::frame_t      pop_frame
);
	import thfd_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	frame_t           mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_frame = mem_q[rd_ptr_q];
	assign do_push   = push_valid && !full;
	assign do_pop    = pop_valid && !pop_stall;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/thfd_back.sv]
// Back end of the frame decoder: scales raw words to hundredths with rounding.
// Two stages: multiply, then divide by 65535 and offset. Depends on thfd_pkg.
`default_nettype none

module thfd_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          pop_valid,
	output logic                               pop_stall,
	input  wire thfd_pkg::frame_t              pop_frame,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [thfd_pkg::TEMP_W-1:0] temp_centi,
	output logic [thfd_pkg::HUMID_W-1:0]       humid_centi,
	output logic                               crc_ok
);
	import thfd_pkg::*;

	localparam int unsigned TN_W = 31;
	localparam int unsigned HN_W = 30;
	localparam logic [TN_W-1:0] TEMP_SPAN   = 31'd17500;
	localparam logic [HN_W-1:0] HUMID_SPAN  = 30'd10000;
	localparam logic [TEMP_W-1:0] TEMP_OFFSET = 15'd4500;
	localparam logic [16:0]       RAW_FULL    = 17'd65535;

	logic            en;
	logic            valid_s1;
	logic            ok_s1;
	logic [TN_W-1:0] tnum_s1;
	logic [HN_W-1:0] hnum_s1;

	logic [TEMP_W-1:0]  tq0;
	logic [16:0]        trem;
	logic [TEMP_W-1:0]  tq;
	logic [HUMID_W-1:0] hq0;
	logic [16:0]        hrem;
	logic [HUMID_W-1:0] hq;

	logic                      out_valid_q;
	logic signed [TEMP_W-1:0]  temp_q;
	logic [HUMID_W-1:0]        humid_q;
	logic                      ok_q;

	assign en        = !out_valid_q || !out_stall;
	assign pop_stall = !en;

	// A value below 2^31 divided by 65535: quotient estimate from the high half,
	// then one correction since the remainder stays below twice the divisor.
	assign tq0  = tnum_s1[30:16];
	assign trem = {1'b0, tnum_s1[15:0]} + 17'(tq0);
	assign tq   = tq0 + TEMP_W'(trem >= RAW_FULL);
	assign hq0  = hnum_s1[29:16];
	assign hrem = {1'b0, hnum_s1[15:0]} + 17'(hq0);
	assign hq   = hq0 + HUMID_W'(hrem >= RAW_FULL);

	always_ff @(posedge clk) begin
		if (en) begin
			tnum_s1 <= TN_W'(pop_frame.temp_raw) * TEMP_SPAN + TN_W'(32767);
			hnum_s1 <= HN_W'(pop_frame.humid_raw) * HUMID_SPAN + HN_W'(32767);
			ok_s1   <= pop_frame.crc_ok;
			temp_q  <= ok_s1 ? $signed(tq - TEMP_OFFSET) : '0;
			humid_q <= ok_s1 ? hq : '0;
			ok_q    <= ok_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= pop_valid;
			out_valid_q <= valid_s1;
		end
	end

	assign out_valid   = out_valid_q;
	assign temp_centi  = temp_q;
	assign humid_centi = humid_q;
	assign crc_ok      = ok_q;

endmodule

`default_nettype wire

[hw/rtl/temp_humidity_frame_decoder.sv]
// Top level of the temperature and humidity frame decoder.
// Instantiates thfd_front, thfd_queue and thfd_back; depends on thfd_pkg.
//
// The block takes one received byte per clock while in_stall is low, and emits one word per
// six-byte frame, carrying temperature in hundredths of a degree, humidity in hundredths of a
// percent and a checksum flag. The unrolled CRC-8 step in the front end is what allows that byte
// rate. A frame's last byte writes the frame into the queue; from there it passes through the
// multiply stage into the output register, where the word becomes valid. The queue holds
// QUEUE_DEPTH frames, so the input stalls only once that many frames wait behind a stalled output.
`default_nettype none

module temp_humidity_frame_decoder #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [7:0]                    rx_byte,
	input  wire logic                          frame_first,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [thfd_pkg::TEMP_W-1:0] temp_centi,
	output logic [thfd_pkg::HUMID_W-1:0]       humid_centi,
	output logic                               crc_ok
);
	import thfd_pkg::*;

	logic   push_valid;
	frame_t push_frame;
	logic   q_full;
	logic   pop_valid;
	logic   pop_stall;
	frame_t pop_frame;

	assign in_stall = q_full;

	thfd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.frame_first (frame_first),
		.push_valid  (push_valid),
		.push_frame  (push_frame)
	);

	thfd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_frame (push_frame),
		.full       (q_full),
		.pop_valid  (pop_valid),
		.pop_stall  (pop_stall),
		.pop_frame  (pop_frame)
	);

	thfd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (pop_valid),
		.pop_stall   (pop_stall),
		.pop_frame   (pop_frame),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.temp_centi  (temp_centi),
		.humid_centi (humid_centi),
		.crc_ok      (crc_ok)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |-> !q_full)
		else $error("Frame pushed into a full queue.");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !crc_ok) |-> (temp_centi == '0 && humid_centi == '0))
		else $error("Nonzero values with a failed checksum.");

	a_humid_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (humid_centi <= HUMID_W'(10000)))
		else $error("Humidity out of range.");

	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (temp_centi >= -TEMP_W'(4500) && temp_centi <= TEMP_W'(13000)))
		else $error("Temperature out of range.");

endmodule

`default_nettype wire

[dv/thfd_frame_checker.sv]
`timescale 1ns / 100ps
// Checker for the temperature and humidity frame decoder: predicts each decoded reading from the
// accepted input bytes and compares every output word with the oldest prediction.
// Depends on thfd_pkg for the field widths.

module thfd_frame_checker (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	input  wire logic                                in_stall,
	input  wire logic [7:0]                          rx_byte,
	input  wire logic                                frame_first,
	input  wire logic                                out_valid,
	input  wire logic                                out_stall,
	input  wire logic signed [thfd_pkg::TEMP_W-1:0]  temp_centi,
	input  wire logic [thfd_pkg::HUMID_W-1:0]        humid_centi,
	input  wire logic                                crc_ok,
	output int unsigned                              fail_count,
	output int unsigned                              readings_pending
);
	import thfd_pkg::*;

	localparam logic [2:0] POS_TEMP_HI  = 3'd0;
	localparam logic [2:0] POS_TEMP_LO  = 3'd1;
	localparam logic [2:0] POS_TEMP_CRC = 3'd2;
	localparam logic [2:0] POS_HUM_HI   = 3'd3;
	localparam logic [2:0] POS_HUM_LO   = 3'd4;
	localparam logic [2:0] POS_HUM_CRC  = 3'd5;
	localparam logic [7:0] CRC_SEED     = 8'hFF;
	localparam logic [7:0] CRC_POLY     = 8'h31;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temp;
		logic [HUMID_W-1:0]       humid;
		logic                     ok;
	} reading_t;

	reading_t    expected_readings[$];
	logic [2:0]  byte_pos;
	logic [7:0]  crc_acc;
	logic [15:0] temp_raw;
	logic [15:0] humid_raw;
	logic        temp_crc_good;
	int unsigned errors;

	function automatic logic [7:0] crc8_byte(logic [7:0] crc, logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++)
			c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
		return c;
	endfunction

	// Full-scale raw words map to span; rounding to nearest, no ties since 65535 is odd.
	function automatic longint scale_centi(logic [15:0] raw, longint span);
		return (longint'(raw) * span * 2 + 65535) / 131070;
	endfunction

	function automatic reading_t decode_reading(logic [7:0] hum_crc);
		reading_t r;
		longint   t;
		r = '0;
		if (temp_crc_good && hum_crc == crc_acc) begin
			t = scale_centi(temp_raw, 17500) - 4500;
			r.temp = t[TEMP_W-1:0];
			r.humid = HUMID_W'(scale_centi(humid_raw, 10000));
			r.ok = 1'b1;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reading_t got;
		reading_t want;
		if (!arst_n) begin
			byte_pos = POS_TEMP_HI;
			crc_acc = CRC_SEED;
			temp_raw = '0;
			humid_raw = '0;
			temp_crc_good = 1'b0;
			errors = 0;
			expected_readings.delete();
			fail_count <= 0;
			readings_pending <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				if (frame_first) begin
					byte_pos = POS_TEMP_HI;
					crc_acc = CRC_SEED;
				end
				case (byte_pos)
					POS_TEMP_HI: begin
						temp_raw = {rx_byte, 8'h00};
						crc_acc = crc8_byte(CRC_SEED, rx_byte);
					end
					POS_TEMP_LO: begin
						temp_raw[7:0] = rx_byte;
						crc_acc = crc8_byte(crc_acc, rx_byte);
					end
					POS_TEMP_CRC: begin
						temp_crc_good = (rx_byte == crc_acc);
						crc_acc = CRC_SEED;
					end
					POS_HUM_HI: begin
						humid_raw = {rx_byte, 8'h00};
						crc_acc = crc8_byte(CRC_SEED, rx_byte);
					end
					POS_HUM_LO: begin
						humid_raw[7:0] = rx_byte;
						crc_acc = crc8_byte(crc_acc, rx_byte);
					end
					default: begin
						expected_readings.push_back(decode_reading(rx_byte));
						crc_acc = CRC_SEED;
					end
				endcase
				byte_pos = (byte_pos == POS_HUM_CRC) ? POS_TEMP_HI : byte_pos + 3'd1;
			end
			if (out_valid && !out_stall) begin
				got = '{temp: temp_centi, humid: humid_centi, ok: crc_ok};
				if (expected_readings.size() == 0) begin
					$error("unexpected output word: temp_centi %0d, humid_centi %0d, crc_ok %0d",
						got.temp, got.humid, got.ok);
					errors++;
				end else begin
					want = expected_readings.pop_front();
					if (got.temp !== want.temp) begin
						$error("temp_centi mismatch: expected %0d, actual %0d", want.temp,
							got.temp);
						errors++;
					end
					if (got.humid !== want.humid) begin
						$error("humid_centi mismatch: expected %0d, actual %0d", want.humid,
							got.humid);
						errors++;
					end
					if (got.ok !== want.ok) begin
						$error("crc_ok mismatch: expected %0d, actual %0d", want.ok, got.ok);
						errors++;
					end
				end
			end
			fail_count <= errors;
			readings_pending <= expected_readings.size();
		end
	end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// Top of the frame decoder testbench: clock, reset, byte stimulus and output stalls.
// Depends on temp_humidity_frame_decoder, thfd_frame_checker and thfd_pkg.

module testbench;
	import thfd_pkg::*;

	localparam int unsigned RANDOM_WORDS = 1700;
	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam logic [7:0] CRC_SEED = 8'hFF;
	localparam logic [7:0] CRC_POLY = 8'h31;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [7:0]                rx_byte = '0;
	logic                      frame_first = 1'b0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic signed [TEMP_W-1:0]  temp_centi;
	logic [HUMID_W-1:0]        humid_centi;
	logic                      crc_ok;
	int unsigned               fail_count;
	int unsigned               readings_pending;

	int unsigned burst_left = 0;
	int unsigned words_sent = 0;
	int unsigned stream_pos = 0;
	int unsigned stall_left = 0;
	int unsigned stall_mode = 0;
	int unsigned cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	temp_humidity_frame_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.frame_first(frame_first),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.temp_centi(temp_centi),
		.humid_centi(humid_centi),
		.crc_ok(crc_ok)
	);

	thfd_frame_checker frame_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.frame_first(frame_first),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.temp_centi(temp_centi),
		.humid_centi(humid_centi),
		.crc_ok(crc_ok),
		.fail_count(fail_count),
		.readings_pending(readings_pending)
	);

	function automatic logic [7:0] word_crc(logic [15:0] w);
		logic [7:0] c;
		c = CRC_SEED ^ w[15:8];
		for (int n = 0; n < 16; n++) begin
			if (n == 8)
				c = c ^ w[7:0];
			c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

	function automatic logic [15:0] pick_raw();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(0, 15));
			3: return 16'hFFFF - 16'($urandom_range(0, 15));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic first);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		rx_byte <= b;
		frame_first <= first;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		stream_pos = first ? 1 : (stream_pos == 5 ? 0 : stream_pos + 1);
		words_sent++;
	endtask

	task automatic send_frame(input logic [15:0] t, input logic [15:0] h, input logic first,
			input logic bad_t, input logic bad_h, input int unsigned count = 6);
		logic [7:0] frame [6];
		frame[0] = t[15:8];
		frame[1] = t[7:0];
		frame[2] = word_crc(t) ^ (bad_t ? 8'($urandom_range(1, 255)) : 8'h00);
		frame[3] = h[15:8];
		frame[4] = h[7:0];
		frame[5] = word_crc(h) ^ (bad_h ? 8'($urandom_range(1, 255)) : 8'h00);
		for (int i = 0; i < count; i++)
			send_byte(frame[i], i == 0 ? first : 1'b0);
	endtask

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(10, 80);
		end
		stall_left--;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= ((stall_left % 16) < 10);
		endcase
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	initial begin
		int unsigned kind;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The first frame after reset carries no first flag and must still decode.
		send_frame(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0);
		send_frame(16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b0);
		send_frame(16'h6666, 16'h8000, 1'b0, 1'b1, 1'b0);
		send_frame(16'h1234, 16'h5678, 1'b1, 1'b0, 1'b0, 2);
		send_frame(16'hA5C3, 16'h0001, 1'b1, 1'b0, 1'b1);

		while (words_sent < RANDOM_WORDS) begin
			kind = $urandom_range(0, 19);
			if (kind < 16)
				send_frame(pick_raw(), pick_raw(),
					stream_pos == 0 ? 1'($urandom_range(0, 1)) : 1'b1,
					$urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
			else if (kind < 18)
				send_frame(pick_raw(), pick_raw(), 1'b1, 1'b0, 1'b0, $urandom_range(1, 5));
			else
				repeat ($urandom_range(1, 4))
					send_byte(8'($urandom), $urandom_range(0, 7) == 0);
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (readings_pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
